// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, codes and cell control type for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned CAPACITY      = 16;
  localparam int unsigned VALUE_BITS    = 32;
  localparam int unsigned PRIORITY_BITS = 16;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Broadcast to every cell in the cycle a command is carried out.
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic [PRIORITY_BITS-1:0] prio;
    logic [VALUE_BITS-1:0]    value;
  } cell_ctrl_t;

endpackage

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a priority and a value, and on each
// command keeps its entry, takes the new entry or takes a neighbour's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                              clk_i,
  input  spq_pkg::cell_ctrl_t               ctrl_i,
  input  logic                              occupied_i,
  input  logic                              left_wants_i,
  input  logic [spq_pkg::PRIORITY_BITS-1:0] left_prio_i,
  input  logic [spq_pkg::VALUE_BITS-1:0]    left_value_i,
  input  logic [spq_pkg::PRIORITY_BITS-1:0] right_prio_i,
  input  logic [spq_pkg::VALUE_BITS-1:0]    right_value_i,
  output logic                              wants_o,
  output logic [spq_pkg::PRIORITY_BITS-1:0] prio_o,
  output logic [spq_pkg::VALUE_BITS-1:0]    value_o
);

  logic [spq_pkg::PRIORITY_BITS-1:0] prio_q, prio_d;
  logic [spq_pkg::VALUE_BITS-1:0]    value_q, value_d;

  // A free slot, or one holding a strictly larger priority, lies behind the
  // insertion point. Equal priorities stay ahead, which keeps FIFO order.
  assign wants_o = !occupied_i || (prio_q > ctrl_i.prio);

  always_comb begin
    prio_d  = prio_q;
    value_d = value_q;
    if (ctrl_i.ins && wants_o) begin
      if (left_wants_i) begin
        prio_d  = left_prio_i;
        value_d = left_value_i;
      end else begin
        prio_d  = ctrl_i.prio;
        value_d = ctrl_i.value;
      end
    end else if (ctrl_i.del) begin
      prio_d  = right_prio_i;
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q  <= prio_d;
    value_q <= value_d;
  end

  assign prio_o  = prio_q;
  assign value_o = value_q;

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held as a chain of cells kept sorted by priority,
// smallest first, with FIFO order among equal priorities.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transfer                 Ports
//  command   in         start && !busy           command_i, data_value_i,
//                                                priority_key_i
//  result    out        result_valid_o (1 cycle) removed_value_o, status_o,
//                                                occupancy_o, queue_empty_o
//
//  One command per cycle: every cell compares against the new priority in
//  parallel and shifts in the same cycle, so busy never rises.
//  The result is registered and appears in the cycle after the transfer, for exactly one cycle.
//  Reset empties the queue at once; cell contents are not cleared.
//  The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start,
  output logic                                     busy,
  input  logic                                     command_i,
  input  logic signed [spq_pkg::VALUE_BITS-1:0]    data_value_i,
  input  logic        [spq_pkg::PRIORITY_BITS-1:0] priority_key_i,
  output logic                                     result_valid_o,
  output logic signed [spq_pkg::VALUE_BITS-1:0]    removed_value_o,
  output logic        [1:0]                        status_o,
  output logic        [spq_pkg::CNT_W-1:0]         occupancy_o,
  output logic                                     queue_empty_o
);

  localparam int unsigned N = spq_pkg::CAPACITY;

  logic                        accept;
  logic                        is_full, is_empty;
  logic                        do_ins, do_del;
  spq_pkg::cell_ctrl_t         ctrl;

  logic [spq_pkg::CNT_W-1:0]   count_q, count_d;
  logic                        valid_q;
  logic [spq_pkg::VALUE_BITS-1:0] removed_q, removed_d;
  spq_pkg::status_e            status_q, status_d;
  logic [spq_pkg::CNT_W-1:0]   occ_q;
  logic                        empty_q;

  logic [N-1:0]                cell_wants;
  logic [N-1:0]                cell_occ;
  logic [spq_pkg::PRIORITY_BITS-1:0] cell_prio  [N];
  logic [spq_pkg::VALUE_BITS-1:0]    cell_value [N];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count_q == spq_pkg::CNT_W'(N));
  assign is_empty = (count_q == '0);
  assign do_ins   = accept && (command_i == spq_pkg::CMD_INSERT) && !is_full;
  assign do_del   = accept && (command_i == spq_pkg::CMD_DELETE) && !is_empty;

  assign ctrl.ins   = do_ins;
  assign ctrl.del   = do_del;
  assign ctrl.prio  = priority_key_i;
  assign ctrl.value = data_value_i;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                              l_wants;
    logic [spq_pkg::PRIORITY_BITS-1:0] l_prio, r_prio;
    logic [spq_pkg::VALUE_BITS-1:0]    l_value, r_value;

    assign cell_occ[i] = (count_q > spq_pkg::CNT_W'(i));

    if (i == 0) begin : g_head
      assign l_wants = 1'b0;
      assign l_prio  = '0;
      assign l_value = '0;
    end else begin : g_body
      assign l_wants = cell_wants[i-1];
      assign l_prio  = cell_prio[i-1];
      assign l_value = cell_value[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign r_prio  = '0;
      assign r_value = '0;
    end else begin : g_mid
      assign r_prio  = cell_prio[i+1];
      assign r_value = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (cell_occ[i]),
      .left_wants_i (l_wants),
      .left_prio_i  (l_prio),
      .left_value_i (l_value),
      .right_prio_i (r_prio),
      .right_value_i(r_value),
      .wants_o      (cell_wants[i]),
      .prio_o       (cell_prio[i]),
      .value_o      (cell_value[i])
    );
  end

  always_comb begin
    count_d   = count_q;
    removed_d = '0;
    status_d  = spq_pkg::ST_DONE;
    if (do_ins) begin
      count_d = count_q + spq_pkg::CNT_W'(1);
    end else if (do_del) begin
      count_d   = count_q - spq_pkg::CNT_W'(1);
      removed_d = cell_value[0];
    end else if (accept) begin
      if (command_i == spq_pkg::CMD_INSERT) begin
        status_d = spq_pkg::ST_FULL;
      end else begin
        status_d = spq_pkg::ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q <= removed_d;
      status_q  <= status_d;
      occ_q     <= count_d;
      empty_q   <= (count_d == '0);
    end
  end

  assign result_valid_o  = valid_q;
  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign occupancy_o     = occ_q;
  assign queue_empty_o   = empty_q;

  // Every transfer yields exactly one result in the following cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_q)
    else $error("command transfer produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !valid_q)
    else $error("result without a command transfer");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= spq_pkg::CNT_W'(N))
    else $error("entry count exceeds capacity");

  a_front_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= spq_pkg::CNT_W'(2)) |-> (cell_prio[0] <= cell_prio[1]))
    else $error("front entries out of priority order");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (status_q == spq_pkg::ST_FULL)) |->
      (occ_q == spq_pkg::CNT_W'(N)) && (removed_q == '0))
    else $error("full status with queue not full");

endmodule

// ----- bench/sorted_priority_queue_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Self-checking bench for the sorted priority queue. Inserts and deletes are
// driven with random gaps, a shadow copy of the queue predicts every result,
// and each result strobe is compared field by field with the oldest pending
// prediction.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 435;

  typedef struct {
    logic signed [spq_pkg::VALUE_BITS-1:0] removed;
    spq_pkg::status_e                      status;
    logic [spq_pkg::CNT_W-1:0]             occupancy;
    logic                                  empty;
  } pq_result_t;

  // Shadow copy of the queue plus the results it has promised.
  class pq_tracker;
    logic [spq_pkg::PRIORITY_BITS-1:0] held_prio [spq_pkg::CAPACITY];
    logic [spq_pkg::VALUE_BITS-1:0]    held_value [spq_pkg::CAPACITY];
    int                                held_count;
    pq_result_t                        pending_results [$];
    int unsigned                       mismatches;

    function new();
      held_count = 0;
      mismatches = 0;
    endfunction

    function void note_command(spq_pkg::command_e cmd,
                               logic [spq_pkg::VALUE_BITS-1:0] value,
                               logic [spq_pkg::PRIORITY_BITS-1:0] prio);
      pq_result_t r;
      int pos;
      r.removed = '0;
      r.status  = spq_pkg::ST_DONE;
      if (cmd == spq_pkg::CMD_INSERT) begin
        if (held_count >= spq_pkg::CAPACITY) begin
          r.status = spq_pkg::ST_FULL;
        end else begin
          // The new entry goes behind every entry of equal or smaller priority value.
          pos = 0;
          while (pos < held_count && held_prio[pos] <= prio) pos++;
          for (int i = held_count; i > pos; i--) begin
            held_prio[i]  = held_prio[i-1];
            held_value[i] = held_value[i-1];
          end
          held_prio[pos]  = prio;
          held_value[pos] = value;
          held_count++;
        end
      end else begin
        if (held_count == 0) begin
          r.status = spq_pkg::ST_EMPTY;
        end else begin
          r.removed = held_value[0];
          for (int i = 1; i < held_count; i++) begin
            held_prio[i-1]  = held_prio[i];
            held_value[i-1] = held_value[i];
          end
          held_count--;
        end
      end
      r.occupancy = spq_pkg::CNT_W'(held_count);
      r.empty     = (held_count == 0);
      pending_results.push_back(r);
    endfunction

    function void check_result(pq_result_t got);
      pq_result_t exp;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing pending: removed %h status %0d occupancy %0d",
                 $time, got.removed, got.status, got.occupancy);
        return;
      end
      exp = pending_results.pop_front();
      if (got.removed !== exp.removed) begin
        mismatches++;
        $display("%0t: removed_value expected %h actual %h", $time, exp.removed, got.removed);
      end
      if (got.status !== exp.status) begin
        mismatches++;
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
      end
      if (got.occupancy !== exp.occupancy) begin
        mismatches++;
        $display("%0t: occupancy expected %0d actual %0d", $time, exp.occupancy,
                 got.occupancy);
      end
      if (got.empty !== exp.empty) begin
        mismatches++;
        $display("%0t: queue_empty expected %b actual %b", $time, exp.empty, got.empty);
      end
    endfunction
  endclass

  logic                                     clk_i          = 1'b0;
  logic                                     rst_ni         = 1'b0;
  logic                                     start          = 1'b0;
  logic                                     busy;
  logic                                     command_i      = spq_pkg::CMD_INSERT;
  logic signed [spq_pkg::VALUE_BITS-1:0]    data_value_i   = '0;
  logic        [spq_pkg::PRIORITY_BITS-1:0] priority_key_i = '0;
  logic                                     result_valid_o;
  logic signed [spq_pkg::VALUE_BITS-1:0]    removed_value_o;
  logic        [1:0]                        status_o;
  logic        [spq_pkg::CNT_W-1:0]         occupancy_o;
  logic                                     queue_empty_o;

  pq_tracker tracker;

  sorted_priority_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .data_value_i   (data_value_i),
    .priority_key_i (priority_key_i),
    .result_valid_o (result_valid_o),
    .removed_value_o(removed_value_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o),
    .queue_empty_o  (queue_empty_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Results are checked before the transfer of the same edge is noted.
  always @(posedge clk_i) begin
    pq_result_t got;
    if (rst_ni) begin
      if (result_valid_o) begin
        got.removed   = removed_value_o;
        got.status    = spq_pkg::status_e'(status_o);
        got.occupancy = occupancy_o;
        got.empty     = queue_empty_o;
        tracker.check_result(got);
      end
      if (start && !busy)
        tracker.note_command(spq_pkg::command_e'(command_i), data_value_i,
                             priority_key_i);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || result_valid_o || !rst_ni) quiet = 0;
      else quiet++;
    end
    $display("sorted_priority_queue_tb: FAIL");
    $finish;
  end

  task automatic send_cmd(input spq_pkg::command_e cmd,
                          input logic [spq_pkg::VALUE_BITS-1:0] value,
                          input logic [spq_pkg::PRIORITY_BITS-1:0] prio,
                          input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    command_i      <= cmd;
    data_value_i   <= value;
    priority_key_i <= prio;
    do @(posedge clk_i); while (busy);
  endtask

  // Sender holds off until every pending result has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk_i); while (tracker.pending_results.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned idle_pct);
    int unsigned insert_bias;
    spq_pkg::command_e cmd;
    logic [spq_pkg::VALUE_BITS-1:0] value;
    logic [spq_pkg::PRIORITY_BITS-1:0] prio;
    insert_bias = 50;
    for (int unsigned k = 0; k < count; k++) begin
      // Bursts leaning towards inserts or deletes walk the queue between
      // empty and full many times over.
      if (k % 40 == 0) begin
        case ($urandom_range(2))
          0: insert_bias = 15;
          1: insert_bias = 50;
          default: insert_bias = 85;
        endcase
      end
      cmd   = ($urandom_range(99) < insert_bias) ? spq_pkg::CMD_INSERT
                                                 : spq_pkg::CMD_DELETE;
      value = ($urandom_range(7) == 0) ?
              {1'($urandom_range(1)), {(spq_pkg::VALUE_BITS-1){1'($urandom_range(1))}}} :
              spq_pkg::VALUE_BITS'($urandom());
      case ($urandom_range(3))
        0: prio = spq_pkg::PRIORITY_BITS'($urandom_range(3));
        1: prio = spq_pkg::PRIORITY_BITS'($urandom_range(15));
        2: prio = spq_pkg::PRIORITY_BITS'($urandom());
        default: begin
          case ($urandom_range(3))
            0: prio = '0;
            1: prio = '1;
            2: prio = {1'b1, {(spq_pkg::PRIORITY_BITS-1){1'b0}}};
            default: prio = {1'b0, {(spq_pkg::PRIORITY_BITS-1){1'b1}}};
          endcase
        end
      endcase
      send_cmd(cmd, value, prio, idle_pct);
    end
  endtask

  initial begin
    int unsigned idle_plan [4];
    idle_plan = '{0, 71, 0, 35};
    tracker = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Underflow on the empty queue, extreme values and priorities, a run of
    // equal priorities, filling up, a rejected insert, then some deletes.
    send_cmd(spq_pkg::CMD_DELETE, 32'h1234_5678, 16'hFFFF, 0);
    send_cmd(spq_pkg::CMD_INSERT, 32'h7FFF_FFFF, 16'hFFFF, 0);
    send_cmd(spq_pkg::CMD_INSERT, 32'h8000_0000, 16'h0000, 0);
    send_cmd(spq_pkg::CMD_INSERT, 32'h0000_0000, 16'h0008, 0);
    send_cmd(spq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 16'h0008, 0);
    send_cmd(spq_pkg::CMD_INSERT, 32'h0000_0001, 16'h0008, 0);
    for (int i = 0; i < 11; i++)
      send_cmd(spq_pkg::CMD_INSERT, 32'(i * 32'h1111_1111), 16'(i * 5000), 0);
    send_cmd(spq_pkg::CMD_INSERT, 32'hDEAD_BEEF, 16'h0000, 0);
    repeat (5)
      send_cmd(spq_pkg::CMD_DELETE, spq_pkg::VALUE_BITS'($urandom()),
               spq_pkg::PRIORITY_BITS'($urandom()), 0);

    foreach (idle_plan[p]) begin
      run_random(PHASE_ITEMS, idle_plan[p]);
      drain_results();
    end

    repeat (4) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
      $display("sorted_priority_queue_tb: PASS");
    else
      $display("sorted_priority_queue_tb: FAIL");
    $finish;
  end

endmodule
